// ===== rtl/qwt_pkg.sv =====
// ----------------------------------------------------------------------------
// qwt_pkg: shared types and constants of the quoted whitespace tokenizer
// Holds the result codes, the sizing constants and the command word that
// passes from the classifier to the result sequencer.
// ----------------------------------------------------------------------------
package qwt_pkg;

  // Line and whitespace buffer limits.
  localparam int MAX_LINE    = 1024;
  localparam int PENDING_MAX = 32;

  localparam int LP_W    = $clog2(MAX_LINE + 1);
  localparam int PEND_CW = $clog2(PENDING_MAX + 1);
  localparam int PEND_IW = (PENDING_MAX > 1) ? $clog2(PENDING_MAX) : 1;

  localparam int FIELD_W = 16;
  localparam int CH_W    = 8;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_LINE  = 2'd3;

  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;

  // Everything one input byte causes, in output order: held blanks,
  // one main result, a field end or error at line end, and line done.
  typedef struct packed {
    logic [PEND_CW-1:0]     nflush;
    logic [PENDING_MAX-1:0] pend_kinds;
    logic                   has_main;
    logic [1:0]             main_kind;
    logic [CH_W-1:0]        main_ch;
    logic [FIELD_W-1:0]     main_idx;
    logic                   has_end;
    logic [1:0]             end_kind;
    logic [FIELD_W-1:0]     end_idx;
    logic                   has_done;
    logic [FIELD_W-1:0]     done_idx;
  } qwt_cmd_t;

endpackage

// ===== rtl/qwt_queue.sv =====
// ----------------------------------------------------------------------------
// qwt_queue: two-entry command queue
// Decouples the classifier from the result sequencer so that either side
// can stall while the other keeps going.
// ----------------------------------------------------------------------------
module qwt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qwt_pkg::qwt_cmd_t din,
  output logic              full,
  input  logic              pop,
  output qwt_pkg::qwt_cmd_t dout,
  output logic              empty
);
  import qwt_pkg::*;

  qwt_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/qwt_front.sv =====
// ----------------------------------------------------------------------------
// qwt_front: byte classifier
// Accepts one byte per cycle unless the queue is full, tracks the line's
// scan state and turns each byte into a command word listing its results.
// ----------------------------------------------------------------------------
module qwt_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,
  input  logic                       s_tlast,
  input  logic [qwt_pkg::FIELD_W-1:0] max_fields,
  output logic                       q_push,
  output qwt_pkg::qwt_cmd_t          q_din,
  input  logic                       q_full
);
  import qwt_pkg::*;

  localparam logic [2:0] MODE_BETWEEN = 3'd0;
  localparam logic [2:0] MODE_PLAIN   = 3'd1;
  localparam logic [2:0] MODE_QUOTED  = 3'd2;
  localparam logic [2:0] MODE_REST    = 3'd3;
  localparam logic [2:0] MODE_DONE    = 3'd4;

  logic [2:0]             mode,       mode_next;
  logic                   qkind,      qkind_next;
  logic [FIELD_W-1:0]     fstarted,   fstarted_next;
  logic [LP_W-1:0]        lpos,       lpos_next;
  logic [PEND_CW-1:0]     pcount,     pcount_next;
  logic [PENDING_MAX-1:0] pkinds,     pkinds_next;
  qwt_cmd_t               cmd;
  logic                   accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_din    = cmd;
  assign q_push   = accept && (cmd.has_main || cmd.has_end || cmd.has_done);

  always_comb begin
    logic [CH_W-1:0]    c;
    logic               blank;
    logic [FIELD_W-1:0] cur;
    logic               closing;

    c       = s_tdata;
    blank   = (c == CH_SPACE) || (c == CH_TAB);
    cur     = fstarted - FIELD_W'(1);
    closing = qkind ? (c == CH_DQUOTE) : (c == CH_SQUOTE);

    mode_next     = mode;
    qkind_next    = qkind;
    fstarted_next = fstarted;
    lpos_next     = lpos;
    pcount_next   = pcount;
    pkinds_next   = pkinds;
    cmd           = '0;

    if (lpos < LP_W'(MAX_LINE)) begin
      if (c == '0) begin
        lpos_next = LP_W'(MAX_LINE);
      end else begin
        lpos_next = lpos + LP_W'(1);
        case (mode)
          MODE_BETWEEN: begin
            if (!blank) begin
              if (fstarted >= max_fields) begin
                mode_next = MODE_DONE;
              end else begin
                fstarted_next = fstarted + FIELD_W'(1);
                if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                  qkind_next = (c == CH_DQUOTE);
                  mode_next  = MODE_QUOTED;
                end else begin
                  cmd.has_main  = 1'b1;
                  cmd.main_kind = KIND_BYTE;
                  cmd.main_ch   = c;
                  cmd.main_idx  = fstarted;
                  mode_next = (fstarted_next == max_fields) ? MODE_REST : MODE_PLAIN;
                end
              end
            end
          end
          MODE_PLAIN: begin
            cmd.has_main  = 1'b1;
            cmd.main_idx  = cur;
            if (blank) begin
              cmd.main_kind = KIND_END;
              mode_next     = MODE_BETWEEN;
            end else begin
              cmd.main_kind = KIND_BYTE;
              cmd.main_ch   = c;
            end
          end
          MODE_QUOTED: begin
            cmd.has_main  = 1'b1;
            cmd.main_idx  = cur;
            if (closing) begin
              cmd.main_kind = KIND_END;
              mode_next     = MODE_BETWEEN;
            end else begin
              cmd.main_kind = KIND_BYTE;
              cmd.main_ch   = c;
            end
          end
          MODE_REST: begin
            if (blank) begin
              // Hold the blank; anything past the buffer limit is dropped.
              if (pcount < PEND_CW'(PENDING_MAX)) begin
                pkinds_next[pcount[PEND_IW-1:0]] = (c == CH_TAB);
                pcount_next = pcount + PEND_CW'(1);
              end
            end else begin
              cmd.nflush     = pcount;
              cmd.pend_kinds = pkinds;
              cmd.has_main   = 1'b1;
              cmd.main_kind  = KIND_BYTE;
              cmd.main_ch    = c;
              cmd.main_idx   = cur;
              pcount_next    = '0;
              pkinds_next    = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (s_tlast) begin
      cmd.end_idx  = fstarted_next - FIELD_W'(1);
      cmd.has_done = 1'b1;
      cmd.done_idx = fstarted_next;
      if ((mode_next == MODE_PLAIN) || (mode_next == MODE_REST)) begin
        cmd.has_end  = 1'b1;
        cmd.end_kind = KIND_END;
      end else if (mode_next == MODE_QUOTED) begin
        // The open quoted field does not count as completed.
        cmd.has_end  = 1'b1;
        cmd.end_kind = KIND_ERROR;
        cmd.done_idx = fstarted_next - FIELD_W'(1);
      end
      mode_next     = MODE_BETWEEN;
      qkind_next    = 1'b0;
      fstarted_next = '0;
      lpos_next     = '0;
      pcount_next   = '0;
      pkinds_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_BETWEEN;
      qkind    <= 1'b0;
      fstarted <= '0;
      lpos     <= '0;
      pcount   <= '0;
      pkinds   <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      qkind    <= qkind_next;
      fstarted <= fstarted_next;
      lpos     <= lpos_next;
      pcount   <= pcount_next;
      pkinds   <= pkinds_next;
    end
  end

endmodule

// ===== rtl/qwt_back.sv =====
// ----------------------------------------------------------------------------
// qwt_back: result sequencer
// Expands the command word at the head of the queue into result words, one
// per cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module qwt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  qwt_pkg::qwt_cmd_t q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);
  import qwt_pkg::*;

  localparam logic [1:0] ST_FLUSH = 2'd0;
  localparam logic [1:0] ST_MAIN  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         stage;
  logic [PEND_IW-1:0] pos;
  logic [3:0]         present;
  logic [1:0]         cur_stage;
  logic               flush_more;
  logic               is_last;
  logic               advance;
  logic [1:0]         r_kind;
  logic [CH_W-1:0]    r_ch;
  logic [FIELD_W-1:0] r_idx;

  always_comb begin
    logic found;
    logic later;

    present[0] = PEND_CW'(pos) < q_head.nflush;
    present[1] = q_head.has_main;
    present[2] = q_head.has_end;
    present[3] = q_head.has_done;

    // First stage at or after the current one that has a result to give.
    found     = 1'b0;
    cur_stage = stage;
    for (int s = 0; s < 4; s++) begin
      if (!found && (2'(s) >= stage) && present[s]) begin
        found     = 1'b1;
        cur_stage = 2'(s);
      end
    end

    later = 1'b0;
    for (int s = 1; s < 4; s++) begin
      if ((2'(s) > cur_stage) && present[s]) begin
        later = 1'b1;
      end
    end

    flush_more = (cur_stage == ST_FLUSH) &&
                 ((PEND_CW'(pos) + PEND_CW'(1)) < q_head.nflush);
    is_last    = !flush_more && !later;

    r_kind = KIND_BYTE;
    r_ch   = '0;
    r_idx  = q_head.main_idx;
    case (cur_stage)
      ST_FLUSH: begin
        r_kind = KIND_BYTE;
        r_ch   = q_head.pend_kinds[pos] ? CH_TAB : CH_SPACE;
        r_idx  = q_head.main_idx;
      end
      ST_MAIN: begin
        r_kind = q_head.main_kind;
        r_ch   = q_head.main_ch;
        r_idx  = q_head.main_idx;
      end
      ST_END: begin
        r_kind = q_head.end_kind;
        r_idx  = q_head.end_idx;
      end
      ST_DONE: begin
        r_kind = KIND_LINE;
        r_idx  = q_head.done_idx;
      end
      default: begin
      end
    endcase
  end

  assign advance = !q_empty && (!m_tvalid || m_tready);
  assign q_pop   = advance && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage    <= ST_FLUSH;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
        if (is_last) begin
          stage <= ST_FLUSH;
          pos   <= '0;
        end else if (flush_more) begin
          stage <= ST_FLUSH;
          pos   <= pos + PEND_IW'(1);
        end else begin
          stage <= cur_stage + 2'd1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {r_idx, r_ch};
      m_tuser <= r_kind;
      m_tlast <= is_last;
    end
  end

endmodule

// ===== rtl/quoted_whitespace_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// quoted_whitespace_tokenizer_unit: quoted whitespace tokenizer, top level
// Path: a byte's result words pass through the command queue and then the
// registered output stage. Throughput: one byte per cycle while each byte
// causes at most one word and the output does not stall; a byte causing
// more holds the sequencer until its last word goes, and the input stalls
// once two commands, the one being expanded included, are queued.
// Reset (rst, synchronous) clears the line state and queue; max_fields -> 65535.
// ----------------------------------------------------------------------------
//
// The line arrives one byte per word on the slave stream, tlast marking the
// final byte. The classifier keeps the scan state of the line (between
// fields, plain field, quoted field, remainder field, or limit reached) and
// writes one command per byte that causes output. The sequencer turns a
// command into its result words in order: buffered blanks of the remainder
// field, the byte's own result, then at line end a field end or an
// unmatched quote error, and finally line done. The last word caused by a
// byte carries tlast.
//
// The only configuration register, max_fields, sits at byte address 0 of
// the register port. It must only be written while the block is idle.
module quoted_whitespace_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // line_end

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] ch_res, [23:8] field_index
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,   // last_of_run

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qwt_pkg::*;

  localparam logic REG_MAX_FIELDS = 1'b0;

  logic [FIELD_W-1:0] max_fields;
  qwt_cmd_t           q_din;
  qwt_cmd_t           q_head;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;

  // Register port: every access completes in its access cycle.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fields <= '1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_FIELDS)) begin
      max_fields <= pwdata[FIELD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_FIELDS) begin
      prdata = 32'(max_fields);
    end
  end

  qwt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .max_fields (max_fields),
    .q_push     (q_push),
    .q_din      (q_din),
    .q_full     (q_full)
  );

  qwt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  qwt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/qwt_checker.sv =====
// ----------------------------------------------------------------------------
// qwt_checker: port-level checks of the tokenizer
// Watches the result stream for ordering and payload rules of the block.
// ----------------------------------------------------------------------------
module qwt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import qwt_pkg::*;

  // A field byte is never zero, since a zero byte ends the line's content.
  a_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_BYTE)) |-> (m_tdata[7:0] != '0))
    else $error("field byte word carries a zero byte");

  // Only field byte words carry a byte.
  a_nonbyte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_BYTE)) |-> (m_tdata[7:0] == '0))
    else $error("non-byte word carries a byte");

  // Line done always closes the run of its byte.
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_LINE)) |-> m_tlast)
    else $error("line done word without last_of_run");

  // An unmatched quote error is always followed by line done.
  a_error_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_ERROR)) |-> !m_tlast)
    else $error("error word ends its run");

  // A stalled word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result word changed");

endmodule

bind quoted_whitespace_tokenizer_unit qwt_checker u_qwt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
